### design/crc16ce_pkg.sv
package crc16ce_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd1;

    // Algorithm modes; any mode with bit 1 set is treated as checksum
    localparam logic [MODE_W-1:0] MODE_CRC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHK = 2'd2;

    localparam logic [WORD_W-1:0] POLY_RESET = 16'h8005;
    localparam logic [WORD_W-1:0] WORD_ZERO  = 16'h0000;

    typedef struct packed {
        logic [WORD_W-1:0] poly;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] next_value;
        logic [WORD_W-1:0] result;
    } dp_out_t;

    // One byte folded into an MSB-first CRC, unrolled over eight bits
    function automatic logic [WORD_W-1:0] crc_byte(
        input logic [WORD_W-1:0] crc,
        input logic [BYTE_W-1:0] data,
        input logic [WORD_W-1:0] poly
    );
        logic [WORD_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (c[WORD_W-1])
            begin
                c = {c[WORD_W-2:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[WORD_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/crc16ce_cfg_regs.sv
module crc16ce_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [crc16ce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crc16ce_pkg::WORD_W-1:0]       cfg_data,
    output crc16ce_pkg::cfg_t                    cfg
);

    logic [crc16ce_pkg::WORD_W-1:0] poly_reg;
    logic [crc16ce_pkg::WORD_W-1:0] poly_next;
    logic [crc16ce_pkg::MODE_W-1:0] mode_reg;
    logic [crc16ce_pkg::MODE_W-1:0] mode_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        poly_next = poly_reg;
        mode_next = mode_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                crc16ce_pkg::REG_POLY: poly_next = cfg_data;
                crc16ce_pkg::REG_MODE: mode_next = cfg_data[crc16ce_pkg::MODE_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= crc16ce_pkg::POLY_RESET;
            mode_reg <= crc16ce_pkg::MODE_CRC;
        end
        else
        begin
            poly_reg <= poly_next;
            mode_reg <= mode_next;
        end
    end

    assign cfg = {poly_reg, mode_reg};

endmodule

### design/crc16ce_datapath.sv
module crc16ce_datapath (
    input  crc16ce_pkg::cfg_t                 cfg,
    input  logic [crc16ce_pkg::WORD_W-1:0]    running_value,
    input  logic [crc16ce_pkg::BYTE_W-1:0]    data,
    output crc16ce_pkg::dp_out_t              dp
);

    logic [crc16ce_pkg::WORD_W-1:0] crc_val;
    logic [crc16ce_pkg::WORD_W-1:0] sum_val;
    logic [crc16ce_pkg::WORD_W-1:0] next_val;
    logic [crc16ce_pkg::WORD_W-1:0] res_val;
    logic [crc16ce_pkg::BYTE_W-1:0] chk_val;

    assign crc_val = crc16ce_pkg::crc_byte(running_value, data, cfg.poly);
    assign sum_val = running_value + {{(crc16ce_pkg::WORD_W-crc16ce_pkg::BYTE_W){1'b0}}, data};

    always_comb
    begin
        case (cfg.mode)
            crc16ce_pkg::MODE_CRC: next_val = crc_val;
            default:               next_val = sum_val;
        endcase
    end

    // two's complement of the sum, low byte only
    assign chk_val = 8'h00 - next_val[crc16ce_pkg::BYTE_W-1:0];

    always_comb
    begin
        case (cfg.mode)
            crc16ce_pkg::MODE_CRC,
            crc16ce_pkg::MODE_SUM: res_val = next_val;
            default:               res_val = {{(crc16ce_pkg::WORD_W-crc16ce_pkg::BYTE_W){1'b0}},
                                              chk_val};
        endcase
    end

    assign dp = {next_val, res_val};

endmodule

### design/crc16_checksum_engine.sv
// crc16_checksum_engine
// Byte-stream checker: CRC-16 (MSB first, polynomial from register 0), a
// 16-bit wrapping byte sum, or an 8-bit two's-complement checksum, picked
// by register 1 (bit 1 set selects checksum).
// Input channel: in_valid/in_ready with data_byte and last_byte. Every item
// is folded into a running value; an item with last_byte set produces one
// result item on check_value (out_valid/out_ready) and clears the value.
// Config channel: cfg_valid/cfg_ready, cfg_index, cfg_data; always ready.
// Write it only while no message item is in flight.
// A last item passes through the input register, then the result register,
// before it is shown on out_valid.
// Throughput: one item per cycle when not stalled; the fold is a single pass
// of eight unrolled XOR-shift steps between the input and result registers.
// Stall: while the result register holds an untaken result, items without
// last_byte still flow through; a second last item waits in the input
// register and in_ready drops until out_ready takes the pending result.
// Reset: rst_n (async, low) empties both registers, zeroes the running
// value, and loads polynomial 0x8005 and CRC mode.
module crc16_checksum_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [crc16ce_pkg::BYTE_W-1:0]       data_byte,
    input  logic                                 last_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [crc16ce_pkg::WORD_W-1:0]       check_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [crc16ce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crc16ce_pkg::WORD_W-1:0]       cfg_data
);

    crc16ce_pkg::cfg_t    cfg;
    crc16ce_pkg::dp_out_t dp;

    // input register
    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic [crc16ce_pkg::BYTE_W-1:0]   s1_data_reg;
    logic                             s1_last_reg;

    // running state
    logic [crc16ce_pkg::WORD_W-1:0]   running_reg;
    logic [crc16ce_pkg::WORD_W-1:0]   running_next;

    // result register
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [crc16ce_pkg::WORD_W-1:0]   result_reg;

    logic out_free;
    logic s1_move;
    logic in_fire;

    crc16ce_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crc16ce_datapath u_dp (
        .cfg           (cfg),
        .running_value (running_reg),
        .data          (s1_data_reg),
        .dp            (dp)
    );

    // result slot is free if empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;
    // a non-last item needs no result slot
    assign s1_move  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        running_next = running_reg;
        if (s1_move)
        begin
            running_next = s1_last_reg ? crc16ce_pkg::WORD_ZERO : dp.next_value;
        end

        out_valid_next = out_valid_reg;
        if (s1_move && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= crc16ce_pkg::WORD_ZERO;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            running_reg   <= running_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_move && s1_last_reg)
        begin
            result_reg <= dp.result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign check_value = result_reg;

endmodule

### design/crc16ce_checker.sv
module crc16ce_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [crc16ce_pkg::WORD_W-1:0]       check_value,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [crc16ce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [crc16ce_pkg::WORD_W-1:0]       cfg_data
);

    // shadow of the mode register, seen from the config port
    logic [crc16ce_pkg::MODE_W-1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= crc16ce_pkg::MODE_CRC;
        end
        else if (cfg_valid && cfg_ready && cfg_index == crc16ce_pkg::REG_MODE)
        begin
            mode_reg <= cfg_data[crc16ce_pkg::MODE_W-1:0];
        end
    end

    // pending result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(check_value))
        else $error("result changed while stalled");

    // input back-pressure only comes from a stalled result
    a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // checksum mode results are one byte wide
    a_chk_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_reg[1] |->
            check_value[crc16ce_pkg::WORD_W-1:crc16ce_pkg::BYTE_W] == 8'h00)
        else $error("checksum result has upper bits set");

    // no stall on an emptying pipe: ready while a result is taken
    a_ready_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("in_ready low while result drains");

endmodule

bind crc16_checksum_engine crc16ce_checker u_crc16ce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .check_value (check_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
);
